>>> design/efr_pkg.sv
package efr_pkg;

  localparam int unsigned MAX_FRAME = 2048;
  localparam int unsigned POS_W     = $clog2(MAX_FRAME + 1);
  localparam int unsigned HDR_LEN   = 7;

  localparam logic [7:0] EAP_TRANSPORT = 8'hE1;
  localparam logic [7:0] FLAG_START    = 8'h10;
  localparam logic [7:0] FLAG_MORE     = 8'h08;
  localparam logic [7:0] FLAG_SIZE     = 8'h07;
  localparam logic [7:0] FLAG_RSVD     = 8'hE0;
  localparam logic [7:0] CODE_REQUEST  = 8'd1;
  localparam logic [7:0] CODE_RESPONSE = 8'd2;
  localparam logic [2:0] SIZE_MAX      = 3'd4;

  localparam logic [POS_W-1:0] POS_CODE   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_IDENT  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(3);
  localparam logic [POS_W-1:0] POS_METHOD = POS_W'(4);
  localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(6);

  // power of two: pointers wrap naturally
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [15:0] CAPACITY_RESET = 16'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCAL_ROLE  = 2'd0,
    REG_EAP_METHOD  = 2'd1,
    REG_CAPACITY    = 2'd2
  } efr_reg_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_REJECT  = 2'd2
  } efr_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE           = 4'd0,
    ERR_FRAME_LONG     = 4'd1,
    ERR_TRANSPORT      = 4'd2,
    ERR_SHORT          = 4'd3,
    ERR_CODE           = 4'd4,
    ERR_METHOD         = 4'd5,
    ERR_LENGTH         = 4'd6,
    ERR_LATE_START     = 4'd7,
    ERR_RESERVED       = 4'd8,
    ERR_NO_START       = 4'd9,
    ERR_SIZE_FIELD     = 4'd10,
    ERR_SHORT_FOR_SIZE = 4'd11,
    ERR_IDENT          = 4'd12,
    ERR_TYPE           = 4'd13,
    ERR_SIZE_LATER     = 4'd14,
    ERR_TOTAL          = 4'd15
  } efr_err_e;

  typedef struct packed {
    logic        local_role;
    logic [7:0]  eap_method;
    logic [15:0] capacity;
  } efr_cfg_t;

  typedef struct packed {
    efr_kind_e   kind;
    logic [7:0]  payload_byte;
    logic [7:0]  message_type;
    logic [15:0] message_length;
    logic [15:0] fragment_count;
    logic [23:0] wire_byte_count;
    efr_err_e    error_code;
  } efr_result_t;

  typedef struct packed {
    logic        pay_vld;
    logic        fin_vld;
    efr_result_t pay;
    efr_result_t fin;
  } efr_push_t;

  function automatic efr_err_e lowest_err(input logic [15:1] hits);
    efr_err_e e;
    e = ERR_NONE;
    for (int i = 15; i >= 1; i--) begin
      if (hits[i]) begin
        e = efr_err_e'(4'(i));
      end
    end
    return e;
  endfunction

  function automatic efr_err_e merge_err(input efr_err_e cur, input efr_err_e add);
    efr_err_e e;
    e = cur;
    if (add != ERR_NONE && (cur == ERR_NONE || add < cur)) begin
      e = add;
    end
    return e;
  endfunction

endpackage

>>> design/efr_if.sv
interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] frame_type;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output frame_type, output end_of_frame,
                  input ready);
  modport sink (input valid, input data_byte, input frame_type, input end_of_frame,
                output ready);
endinterface

interface efr_out_if;
  import efr_pkg::*;
  logic        valid;
  logic        ready;
  efr_kind_e   kind;
  logic [7:0]  payload_byte;
  logic [7:0]  message_type;
  logic [15:0] message_length;
  logic [15:0] fragment_count;
  logic [23:0] wire_byte_count;
  efr_err_e    error_code;

  modport source (output valid, output kind, output payload_byte, output message_type,
                  output message_length, output fragment_count, output wire_byte_count,
                  output error_code, input ready);
  modport sink (input valid, input kind, input payload_byte, input message_type,
                input message_length, input fragment_count, input wire_byte_count,
                input error_code, output ready);
endinterface

interface efr_cfg_if;
  import efr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/efr_core.sv
module efr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         frame_type_i,
  input  logic               end_of_frame_i,
  input  efr_pkg::efr_cfg_t  cfg_i,
  output efr_pkg::efr_push_t push_o
);
  import efr_pkg::*;

  logic             in_msg_q,  in_msg_d;
  logic [7:0]       ident_q,   ident_d;
  logic [7:0]       type_q,    type_d;
  logic [31:0]      ann_q,     ann_d;
  logic             tot_q,     tot_d;
  logic [15:0]      gath_q,    gath_d;
  logic [15:0]      frames_q,  frames_d;
  logic [23:0]      wire_q,    wire_d;
  logic [POS_W-1:0] pos_q,     pos_d;
  logic [15:0]      hlen_q,    hlen_d;
  logic [7:0]       flags_q,   flags_d;
  efr_err_e         pend_q,    pend_d;
  logic             foreign_q, foreign_d;

  logic             first;
  logic [15:1]      hits;
  logic [2:0]       size_b;
  logic [2:0]       size_need;
  logic [2:0]       size_f;
  logic             emit;
  efr_err_e         err_all;
  efr_kind_e        fin_kind;
  efr_err_e         fin_err;

  always_comb begin
    in_msg_d  = in_msg_q;
    ident_d   = ident_q;
    type_d    = type_q;
    ann_d     = ann_q;
    tot_d     = tot_q;
    gath_d    = gath_q;
    frames_d  = frames_q;
    wire_d    = wire_q;
    pos_d     = pos_q;
    hlen_d    = hlen_q;
    flags_d   = flags_q;
    foreign_d = foreign_q;
    hits      = '0;
    emit      = 1'b0;
    fin_kind  = KIND_DONE;
    fin_err   = ERR_NONE;
    first     = !in_msg_q;
    size_b    = 3'(data_byte_i & FLAG_SIZE);
    size_need = 3'(flags_q & FLAG_SIZE);
    if (!first || size_need > SIZE_MAX) begin
      size_need = '0;
    end

    if (pos_q == POS_CODE) begin
      foreign_d = (frame_type_i != EAP_TRANSPORT);
      flags_d   = '0;
      hlen_d    = '0;
      if (foreign_d) begin
        hits[ERR_TRANSPORT] = 1'b1;
      end else if (frames_q != '1) begin
        frames_d = frames_q + 16'd1;
      end
    end
    if (!foreign_d && wire_q != '1) begin
      wire_d = wire_q + 24'd1;
    end

    if (pos_q >= POS_W'(MAX_FRAME)) begin
      hits[ERR_FRAME_LONG] = 1'b1;
    end else begin
      case (pos_q)
        POS_CODE: begin
          if (data_byte_i != (cfg_i.local_role ? CODE_RESPONSE : CODE_REQUEST)) begin
            hits[ERR_CODE] = 1'b1;
          end
        end
        POS_IDENT: begin
          if (first) begin
            ident_d = data_byte_i;
          end else if (data_byte_i != ident_q) begin
            hits[ERR_IDENT] = 1'b1;
          end
        end
        POS_LEN_HI: hlen_d = {data_byte_i, 8'h00};
        POS_LEN_LO: hlen_d = hlen_q | {8'h00, data_byte_i};
        POS_METHOD: begin
          if (data_byte_i != cfg_i.eap_method) begin
            hits[ERR_METHOD] = 1'b1;
          end
        end
        POS_FLAGS: begin
          flags_d = data_byte_i;
          if ((data_byte_i & FLAG_START) != '0 && !first) begin
            hits[ERR_LATE_START] = 1'b1;
          end
          if ((data_byte_i & FLAG_RSVD) != '0) begin
            hits[ERR_RESERVED] = 1'b1;
          end
          if (first) begin
            if ((data_byte_i & FLAG_START) == '0) begin
              hits[ERR_NO_START] = 1'b1;
            end
            if (size_b > SIZE_MAX) begin
              hits[ERR_SIZE_FIELD] = 1'b1;
            end else if (size_b != '0) begin
              tot_d = 1'b1;
              ann_d = '0;
            end
          end else if (size_b != '0) begin
            hits[ERR_SIZE_LATER] = 1'b1;
          end
        end
        POS_TYPE: begin
          if (first) begin
            type_d = data_byte_i;
          end else if (data_byte_i != type_q) begin
            hits[ERR_TYPE] = 1'b1;
          end
        end
        default: begin
          if (pos_q < POS_W'(HDR_LEN) + POS_W'(size_need)) begin
            ann_d = {ann_q[23:0], data_byte_i};
          end else if ({1'b0, gath_q} + 17'd1 > {1'b0, cfg_i.capacity}) begin
            hits[ERR_TOTAL] = 1'b1;
          end else if (pend_q == ERR_NONE) begin
            gath_d = gath_q + 16'd1;
            emit   = 1'b1;
          end
        end
      endcase
      pos_d = pos_q + 1'b1;
    end

    size_f = 3'(flags_d & FLAG_SIZE);
    if (end_of_frame_i) begin
      if (pos_d < POS_W'(HDR_LEN)) begin
        hits[ERR_SHORT] = 1'b1;
      end
      if (hlen_d != 16'(pos_d)) begin
        hits[ERR_LENGTH] = 1'b1;
      end
      if (first && size_f != '0 && size_f <= SIZE_MAX &&
          pos_d < POS_W'(HDR_LEN) + POS_W'(size_f)) begin
        hits[ERR_SHORT_FOR_SIZE] = 1'b1;
      end
    end

    err_all = merge_err(pend_q, lowest_err(hits));
    pend_d  = err_all;

    push_o.pay_vld = fire_i && emit;
    // a frame with more to follow and no error ends without a record
    push_o.fin_vld = fire_i && end_of_frame_i &&
                     (err_all != ERR_NONE || (flags_d & FLAG_MORE) == '0);
    push_o.pay     = '{kind: KIND_PAYLOAD, payload_byte: data_byte_i, message_type: type_d,
                       message_length: gath_d, fragment_count: frames_d,
                       wire_byte_count: wire_d, error_code: ERR_NONE};

    if (end_of_frame_i) begin
      pos_d = '0;
      if (err_all != ERR_NONE) begin
        fin_kind = KIND_REJECT;
        fin_err  = err_all;
      end else if (tot_d && {16'h0000, gath_d} != ann_d) begin
        fin_kind = KIND_REJECT;
        fin_err  = ERR_TOTAL;
      end
      if (err_all != ERR_NONE || (flags_d & FLAG_MORE) == '0) begin
        in_msg_d  = 1'b0;
        ident_d   = '0;
        type_d    = '0;
        ann_d     = '0;
        tot_d     = 1'b0;
        gath_d    = '0;
        frames_d  = '0;
        wire_d    = '0;
        hlen_d    = '0;
        flags_d   = '0;
        pend_d    = ERR_NONE;
        foreign_d = 1'b0;
      end else begin
        in_msg_d = 1'b1;
      end
    end

    push_o.fin = '{kind: fin_kind, payload_byte: 8'h00, message_type: push_o.pay.message_type,
                   message_length: push_o.pay.message_length,
                   fragment_count: push_o.pay.fragment_count,
                   wire_byte_count: push_o.pay.wire_byte_count, error_code: fin_err};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q  <= 1'b0;
      ident_q   <= '0;
      type_q    <= '0;
      ann_q     <= '0;
      tot_q     <= 1'b0;
      gath_q    <= '0;
      frames_q  <= '0;
      wire_q    <= '0;
      pos_q     <= '0;
      hlen_q    <= '0;
      flags_q   <= '0;
      pend_q    <= ERR_NONE;
      foreign_q <= 1'b0;
    end else if (fire_i) begin
      in_msg_q  <= in_msg_d;
      ident_q   <= ident_d;
      type_q    <= type_d;
      ann_q     <= ann_d;
      tot_q     <= tot_d;
      gath_q    <= gath_d;
      frames_q  <= frames_d;
      wire_q    <= wire_d;
      pos_q     <= pos_d;
      hlen_q    <= hlen_d;
      flags_q   <= flags_d;
      pend_q    <= pend_d;
      foreign_q <= foreign_d;
    end
  end

endmodule

>>> design/efr_out_fifo.sv
module efr_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  efr_pkg::efr_push_t              push_i,
  efr_out_if.source                       out_o,
  output logic [efr_pkg::OUT_CNT_W-1:0]   level_o
);
  import efr_pkg::*;

  efr_result_t            mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_q, wr_d;
  logic [OUT_PTR_W-1:0]   rd_q, rd_d;
  logic [OUT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [OUT_PTR_W-1:0]   fin_addr;
  logic                   pop;
  efr_result_t            head;

  assign pop      = out_o.valid && out_o.ready;
  assign fin_addr = wr_q + OUT_PTR_W'(push_i.pay_vld);

  always_comb begin
    wr_d  = wr_q + OUT_PTR_W'(push_i.pay_vld) + OUT_PTR_W'(push_i.fin_vld);
    rd_d  = rd_q + OUT_PTR_W'(pop);
    cnt_d = cnt_q + OUT_CNT_W'(push_i.pay_vld) + OUT_CNT_W'(push_i.fin_vld)
          - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.pay_vld) begin
      mem_q[wr_q] <= push_i.pay;
    end
    if (push_i.fin_vld) begin
      mem_q[fin_addr] <= push_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head                  = mem_q[rd_q];
  assign out_o.valid           = (cnt_q != '0);
  assign out_o.kind            = head.kind;
  assign out_o.payload_byte    = head.payload_byte;
  assign out_o.message_type    = head.message_type;
  assign out_o.message_length  = head.message_length;
  assign out_o.fragment_count  = head.fragment_count;
  assign out_o.wire_byte_count = head.wire_byte_count;
  assign out_o.error_code      = head.error_code;
  assign level_o               = cnt_q;

endmodule

>>> design/eap_fragment_reassembler.sv
// EAP-EDHOC receive reassembler. Frame bytes enter one per beat and are checked and counted
// combinationally against the held message state; payload bytes, completions and rejections
// leave through a four-entry result queue, first visible the cycle after the byte is taken.
// Throughput is one byte per clock. The last byte of a frame may push two results (a
// payload byte and the end-of-message record), and the queue drains one result per clock
// while the output is ready, so input ready drops whenever fewer than two queue entries
// are free. No clearing pass after reset; configuration writes are taken in any cycle.
module eap_fragment_reassembler (
  input  logic       clk_i,
  input  logic       rst_ni,
  efr_in_if.sink     in_i,
  efr_cfg_if.sink    cfg_i,
  efr_out_if.source  out_o
);
  import efr_pkg::*;

  efr_cfg_t               cfg_q;
  efr_push_t              push;
  logic [OUT_CNT_W-1:0]   level;
  logic                   fire;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (level <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign fire        = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_role  <= 1'b0;
      cfg_q.eap_method  <= '0;
      cfg_q.capacity    <= CAPACITY_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_LOCAL_ROLE:  cfg_q.local_role  <= cfg_i.data[0];
        REG_EAP_METHOD:  cfg_q.eap_method  <= cfg_i.data[7:0];
        REG_CAPACITY:    cfg_q.capacity    <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  efr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .data_byte_i    (in_i.data_byte),
    .frame_type_i   (in_i.frame_type),
    .end_of_frame_i (in_i.end_of_frame),
    .cfg_i          (cfg_q),
    .push_o         (push)
  );

  efr_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .out_o   (out_o),
    .level_o (level)
  );

`ifndef SYNTHESIS
  a_push_needs_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.pay_vld || push.fin_vld) |-> fire)
    else $error("result pushed without an input beat");

  a_reject_has_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.fin_vld |-> ((push.fin.kind == KIND_REJECT) == (push.fin.error_code != ERR_NONE)))
    else $error("end record kind and error code disagree");

  a_eof_leaves_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.fin_vld |=> (level != '0))
    else $error("message end left no queued result");
`endif

endmodule
